[hdl/ppis_pkg.sv]
// shared types and constants of the pulse period item splitter
package ppis_pkg;

	localparam int DEF_DURATION_BITS = 15;
	localparam int DEF_COUNT_BITS    = 20;
	localparam int OUT_DUR_BITS      = 15;
	localparam int MAX_RESULTS       = 34;
	localparam int CNT_BITS          = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HIGH,
		ST_LOW
	} state_t;

	// output item, first field in the lowest bits
	typedef struct packed {
		logic                    second_level;
		logic [OUT_DUR_BITS-1:0] second_duration;
		logic                    first_level;
		logic [OUT_DUR_BITS-1:0] first_duration;
	} item_t;

	// compare flags from the shared segment unit
	typedef struct packed {
		logic gt_two;
		logic gt_seg;
	} seg_cmp_t;

endpackage

[hdl/ppis_seg_unit.sv]
// shared compare and subtract unit against one and two full segments
module ppis_seg_unit #(
	parameter int COUNT_BITS    = ppis_pkg::DEF_COUNT_BITS,
	parameter int DURATION_BITS = ppis_pkg::DEF_DURATION_BITS
) (
	input  logic [COUNT_BITS-1:0] x,
	output ppis_pkg::seg_cmp_t    cmp,
	output logic [COUNT_BITS-1:0] minus_two,
	output logic [COUNT_BITS-1:0] minus_seg
);
	import ppis_pkg::*;

	localparam logic [COUNT_BITS-1:0] SEG = COUNT_BITS'((1 << DURATION_BITS) - 1);
	localparam logic [COUNT_BITS-1:0] TWO = COUNT_BITS'(2 * ((1 << DURATION_BITS) - 1));

	assign cmp.gt_two = x > TWO;
	assign cmp.gt_seg = x > SEG;
	assign minus_two  = x - TWO;
	assign minus_seg  = x - SEG;

endmodule

[hdl/pulse_period_item_splitter_core.sv]
// top level: splits one high/low period into a run of two-segment pulse items
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: high_count, low_count
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: first_duration, first_level,
//                                             second_duration, second_level; tlast: last
//
// rate: a taken period yields one output item per cycle while the sink keeps up, and the
//   input stays closed until the last item of the run has been produced
// the items are formed with the single shared compare/subtract unit stepped by the sequencer
// reset: arst_n clears the sequencer, item counter and output valid; nothing else
// stalls: a low m_axis_tready with an item waiting freezes the sequencer; the last item of a run waits in
//   the output register while the next period is already accepted
module pulse_period_item_splitter_core #(
	parameter int DURATION_BITS = ppis_pkg::DEF_DURATION_BITS,
	parameter int COUNT_BITS    = ppis_pkg::DEF_COUNT_BITS
) (
	input  logic clk,
	input  logic arst_n,
	// tdata: high_count, low_count (lowest bit up), zero padded to bytes
	input  logic [((2*COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: first_duration, first_level, second_duration, second_level (lowest bit up)
	output ppis_pkg::item_t                   m_axis_tdata,
	output logic                              m_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready
);
	import ppis_pkg::*;

	localparam logic [DURATION_BITS-1:0] SEG_D = '1;

	state_t                 state_q, state_d;
	logic [COUNT_BITS-1:0]  hi_q, hi_d;
	logic [COUNT_BITS-1:0]  lo_q, lo_d;
	logic [CNT_BITS-1:0]    cnt_q;
	item_t                  item_q, item_d;
	logic                   last_q, last_d;
	logic                   out_valid_q;

	logic                   accept;
	logic                   step;
	logic                   cap;
	logic                   done;
	logic [COUNT_BITS-1:0]  unit_x;
	seg_cmp_t               cmp;
	logic [COUNT_BITS-1:0]  x_minus_two;
	logic [COUNT_BITS-1:0]  x_minus_seg;
	logic                   lo_gt_seg;
	logic [COUNT_BITS-1:0]  lo_minus_seg;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	// advance only when the output register is free or being emptied
	assign step          = (state_q != ST_IDLE) && (!out_valid_q || m_axis_tready);
	// run truncated at the item limit
	assign cap           = (cnt_q == CNT_BITS'(MAX_RESULTS - 1));

	// the shared unit works on the high count first, then on the low count
	assign unit_x = (state_q == ST_LOW) ? lo_q : hi_q;

	ppis_seg_unit #(
		.COUNT_BITS    (COUNT_BITS),
		.DURATION_BITS (DURATION_BITS)
	) u_seg (
		.x         (unit_x),
		.cmp       (cmp),
		.minus_two (x_minus_two),
		.minus_seg (x_minus_seg)
	);

	// pad taken from the low time when the high tail closes with a low segment
	assign lo_gt_seg    = lo_q > COUNT_BITS'(SEG_D);
	assign lo_minus_seg = lo_q - COUNT_BITS'(SEG_D);

	// item and remainder for the current step
	always_comb begin
		item_d = '0;
		last_d = 1'b0;
		hi_d   = hi_q;
		lo_d   = lo_q;
		unique case (state_q)
			ST_HIGH: begin
				item_d.first_level    = 1'b1;
				item_d.first_duration = OUT_DUR_BITS'(SEG_D);
				if (cmp.gt_two) begin
					// full high item
					item_d.second_duration = OUT_DUR_BITS'(SEG_D);
					item_d.second_level    = 1'b1;
					hi_d                   = x_minus_two;
					last_d                 = 1'b0;
				end else if (cmp.gt_seg) begin
					// high tail fills both segments
					item_d.second_duration = OUT_DUR_BITS'(x_minus_seg[DURATION_BITS-1:0]);
					item_d.second_level    = 1'b1;
					last_d                 = (lo_q == '0);
				end else begin
					// short high tail closed by a low pad
					item_d.first_duration = OUT_DUR_BITS'(hi_q[DURATION_BITS-1:0]);
					item_d.second_level   = 1'b0;
					if (lo_gt_seg) begin
						item_d.second_duration = OUT_DUR_BITS'(SEG_D);
						lo_d                   = lo_minus_seg;
						last_d                 = 1'b0;
					end else begin
						item_d.second_duration = OUT_DUR_BITS'(lo_q[DURATION_BITS-1:0]);
						lo_d                   = '0;
						last_d                 = 1'b1;
					end
				end
			end
			ST_LOW: begin
				item_d.first_level  = 1'b0;
				item_d.second_level = 1'b0;
				if (cmp.gt_two) begin
					item_d.first_duration  = OUT_DUR_BITS'(SEG_D);
					item_d.second_duration = OUT_DUR_BITS'(SEG_D);
					lo_d                   = x_minus_two;
					last_d                 = 1'b0;
				end else if (cmp.gt_seg) begin
					item_d.first_duration  = OUT_DUR_BITS'(SEG_D);
					item_d.second_duration = OUT_DUR_BITS'(x_minus_seg[DURATION_BITS-1:0]);
					last_d                 = 1'b1;
				end else begin
					item_d.first_duration  = OUT_DUR_BITS'(lo_q[DURATION_BITS-1:0]);
					item_d.second_duration = '0;
					last_d                 = 1'b1;
				end
			end
			default: begin
				last_d = 1'b0;
			end
		endcase
		if (cap) begin
			last_d = 1'b1;
		end
	end

	assign done = last_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HIGH;
				end
			end
			ST_HIGH: begin
				if (step) begin
					if (done) begin
						state_d = ST_IDLE;
					end else if (cmp.gt_two) begin
						state_d = ST_HIGH;
					end else begin
						state_d = ST_LOW;
					end
				end
			end
			ST_LOW: begin
				if (step && done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// counts and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q <= s_axis_tdata[COUNT_BITS-1:0];
			lo_q <= s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
		end else if (step) begin
			hi_q <= hi_d;
			lo_q <= lo_d;
		end
		if (step) begin
			item_q <= item_d;
			last_q <= last_d;
		end
	end

	assign m_axis_tdata  = item_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tvalid = out_valid_q;

endmodule

[hdl/ppis_checker.sv]
// port level checks of the pulse period item splitter, bound to the top level
module ppis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	// a taken period keeps the input closed in the next cycle
	ap_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still open after a period transfer");

	// a new item appears only while a period is being worked on
	ap_item_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("item produced while idle");

	// the input reopens only with the final item of the run in the output register
	ap_reopen_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
		else $error("input reopened before the last item");

	// a stalled item holds
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output item changed");

endmodule

bind pulse_period_item_splitter_core ppis_checker u_ppis_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
